>>> hw/rtl/tspfb_pkg.sv
// shared types, constants and helpers for the tcp syn probe frame builder
package tspfb_pkg;

	localparam int unsigned IndexWidth = 3;
	localparam int unsigned PosWidth   = 5;
	localparam int unsigned SumWidth   = 20;

	localparam logic [PosWidth-1:0] LastWord = 5'd26;

	localparam logic [15:0] EthTypeIpv4 = 16'h0800;
	localparam logic [15:0] IpVerIhl    = 16'h4500;
	localparam logic [15:0] IpFlagsDf   = 16'h4000;
	localparam logic [15:0] IpTtlProto  = 16'h2806;
	localparam logic [15:0] IpBaseLen   = 16'd40;
	localparam logic [15:0] TcpOffSyn   = 16'h5002;
	localparam logic [15:0] TcpWindow   = 16'd8196;
	localparam logic [15:0] Mask16      = 16'hffff;

	typedef enum logic [IndexWidth-1:0] {
		RegSourceMac     = 3'd0,
		RegRouterMac     = 3'd1,
		RegSourceIp      = 3'd2,
		RegLocalPort     = 3'd3,
		RegPayloadLength = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [47:0] source_mac;
		logic [47:0] router_mac;
		logic [31:0] source_ip;
		logic [15:0] local_port;
		logic [15:0] payload_length;
	} cfg_t;

	typedef struct packed {
		logic [31:0] dest_ip;
		logic [15:0] ident;
		logic [15:0] probe_port;
		logic [15:0] csum;
	} job_t;

	function automatic logic [15:0] total_length(input logic [15:0] payload_length);
		total_length = IpBaseLen + payload_length;
	endfunction

endpackage

>>> hw/rtl/tspfb_front.sv
// request intake and ipv4 header checksum
module tspfb_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [31:0]         dest_ip,
	input  logic [15:0]         ident,
	input  logic [15:0]         probe_port,
	input  tspfb_pkg::cfg_t     cfg,
	output logic                q_push,
	output tspfb_pkg::job_t     q_data,
	input  logic                q_full
);

	logic        valid_s1;
	logic [31:0] dest_ip_s1;
	logic [15:0] ident_s1;
	logic [15:0] probe_port_s1;
	logic [17:0] psum_s1;
	logic        load;
	logic [tspfb_pkg::SumWidth-1:0] acc;
	logic [16:0] fold1;
	logic [15:0] fold2;

	assign full   = valid_s1 & q_full;
	assign load   = push & ~full;
	assign q_push = valid_s1 & ~q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= load | (valid_s1 & q_full);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dest_ip_s1    <= dest_ip;
			ident_s1      <= ident;
			probe_port_s1 <= probe_port;
			psum_s1       <= {2'b00, dest_ip[31:16]} + {2'b00, dest_ip[15:0]}
				+ {2'b00, ident};
		end
	end

	// one's-complement sum of the ten header words, checksum word taken as zero
	always_comb begin
		acc = {2'b00, psum_s1}
			+ {4'h0, tspfb_pkg::IpVerIhl}
			+ {4'h0, tspfb_pkg::IpFlagsDf}
			+ {4'h0, tspfb_pkg::IpTtlProto}
			+ {4'h0, tspfb_pkg::total_length(cfg.payload_length)}
			+ {4'h0, cfg.source_ip[31:16]}
			+ {4'h0, cfg.source_ip[15:0]};
		fold1 = {13'd0, acc[19:16]} + {1'b0, acc[15:0]};
		fold2 = fold1[15:0] + {15'd0, fold1[16]};
	end

	always_comb begin
		q_data.dest_ip    = dest_ip_s1;
		q_data.ident      = ident_s1;
		q_data.probe_port = probe_port_s1;
		q_data.csum       = ~fold2 & tspfb_pkg::Mask16;
	end

endmodule

>>> hw/rtl/tspfb_fifo.sv
// two-entry job queue between front and back end
module tspfb_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  tspfb_pkg::job_t wdata,
	output logic            full,
	input  logic            rd,
	output tspfb_pkg::job_t rdata,
	output logic            empty
);

	tspfb_pkg::job_t ent0_q;
	tspfb_pkg::job_t ent1_q;
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            do_wr;
	logic            do_rd;

	assign full  = count_q == 2'd2;
	assign empty = count_q == 2'd0;
	assign do_wr = wr & ~full;
	assign do_rd = rd & ~empty;
	assign rdata = rd_ptr_q ? ent1_q : ent0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr && !wr_ptr_q) begin
			ent0_q <= wdata;
		end
		if (do_wr && wr_ptr_q) begin
			ent1_q <= wdata;
		end
	end

endmodule

>>> hw/rtl/tspfb_back.sv
// header word serializer with output register
module tspfb_back (
	input  logic                clk,
	input  logic                arst_n,
	input  tspfb_pkg::cfg_t     cfg,
	input  tspfb_pkg::job_t     q_data,
	input  logic                q_empty,
	output logic                q_pop,
	output logic [15:0]         frame_word,
	output logic                last_word,
	output logic                empty,
	input  logic                pop
);

	tspfb_pkg::job_t                job_q;
	logic                           busy_q;
	logic [tspfb_pkg::PosWidth-1:0] pos_q;
	logic                           out_valid_q;
	logic [15:0]                    word_q;
	logic                           last_q;
	logic                           advance;
	logic                           at_last;
	logic                           take;
	logic [15:0]                    word;

	assign advance = ~out_valid_q | pop;
	assign at_last = pos_q == tspfb_pkg::LastWord;
	assign take    = ~q_empty & (~busy_q | (advance & at_last));
	assign q_pop   = take;

	always_comb begin
		case (pos_q)
			5'd0:    word = cfg.router_mac[47:32];
			5'd1:    word = cfg.router_mac[31:16];
			5'd2:    word = cfg.router_mac[15:0];
			5'd3:    word = cfg.source_mac[47:32];
			5'd4:    word = cfg.source_mac[31:16];
			5'd5:    word = cfg.source_mac[15:0];
			5'd6:    word = tspfb_pkg::EthTypeIpv4;
			5'd7:    word = tspfb_pkg::IpVerIhl;
			5'd8:    word = tspfb_pkg::total_length(cfg.payload_length);
			5'd9:    word = job_q.ident;
			5'd10:   word = tspfb_pkg::IpFlagsDf;
			5'd11:   word = tspfb_pkg::IpTtlProto;
			5'd12:   word = job_q.csum;
			5'd13:   word = cfg.source_ip[31:16];
			5'd14:   word = cfg.source_ip[15:0];
			5'd15:   word = job_q.dest_ip[31:16];
			5'd16:   word = job_q.dest_ip[15:0];
			5'd17:   word = cfg.local_port;
			5'd18:   word = job_q.probe_port;
			5'd23:   word = tspfb_pkg::TcpOffSyn;
			5'd24:   word = tspfb_pkg::TcpWindow;
			default: word = 16'h0000;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= busy_q;
			end
			if (take) begin
				busy_q <= 1'b1;
				pos_q  <= '0;
			end else if (advance && busy_q) begin
				if (at_last) begin
					busy_q <= 1'b0;
					pos_q  <= '0;
				end else begin
					pos_q <= pos_q + 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			job_q <= q_data;
		end
		if (advance && busy_q) begin
			word_q <= word;
			last_q <= at_last;
		end
	end

	assign frame_word = word_q;
	assign last_word  = last_q;
	assign empty      = ~out_valid_q;

`ifndef SYNTH
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> pos_q <= tspfb_pkg::LastWord)
		else $error("word position past end of frame");

	a_idle_pos: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> pos_q == '0)
		else $error("word position not cleared while idle");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && busy_q && at_last) |=> (out_valid_q && last_q))
		else $error("final word not flagged");

	a_mid_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && busy_q && !at_last) |=> (out_valid_q && !last_q))
		else $error("inner word flagged as last");
`endif

endmodule

>>> hw/rtl/tcp_syn_probe_frame_builder_core.sv
// top level of the tcp syn probe frame builder
// Each accepted request yields 27 header words (Ethernet, IPv4 with its
// header checksum, TCP SYN), one word per cycle while pop keeps up, the
// last one flagged by last_word. Sustained rate is set by the back end's
// one-word-per-cycle serializer; the front end computes the checksum and
// holds up to three further requests (one in its checksum stage, two in a
// queue), so push is taken while a frame is still being sent. From idle, a
// taken request passes the checksum stage, the queue, the back-end job
// register and the output register before its first word appears. The
// user must write configuration via cfg_we/cfg_index/cfg_data only while
// the block is idle, which it does not enforce; unknown indices are ignored.
module tcp_syn_probe_frame_builder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [31:0] dest_ip,
	input  logic [15:0] ident,
	input  logic [15:0] probe_port,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] frame_word,
	output logic        last_word
);

	tspfb_pkg::cfg_t cfg_q;
	tspfb_pkg::job_t fq_wdata;
	tspfb_pkg::job_t fq_rdata;
	logic            fq_wr;
	logic            fq_full;
	logic            fq_rd;
	logic            fq_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (tspfb_pkg::cfg_reg_t'(cfg_index))
				tspfb_pkg::RegSourceMac:     cfg_q.source_mac     <= cfg_data;
				tspfb_pkg::RegRouterMac:     cfg_q.router_mac     <= cfg_data;
				tspfb_pkg::RegSourceIp:      cfg_q.source_ip      <= cfg_data[31:0];
				tspfb_pkg::RegLocalPort:     cfg_q.local_port     <= cfg_data[15:0];
				tspfb_pkg::RegPayloadLength: cfg_q.payload_length <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	tspfb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.dest_ip    (dest_ip),
		.ident      (ident),
		.probe_port (probe_port),
		.cfg        (cfg_q),
		.q_push     (fq_wr),
		.q_data     (fq_wdata),
		.q_full     (fq_full)
	);

	tspfb_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (fq_wr),
		.wdata  (fq_wdata),
		.full   (fq_full),
		.rd     (fq_rd),
		.rdata  (fq_rdata),
		.empty  (fq_empty)
	);

	tspfb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_data     (fq_rdata),
		.q_empty    (fq_empty),
		.q_pop      (fq_rd),
		.frame_word (frame_word),
		.last_word  (last_word),
		.empty      (empty),
		.pop        (pop)
	);

endmodule
